/* rtl/core/nsm_pkg.sv */
// ----------------------------------------------------------------------------
// nsm_pkg
// Shared constants and lookup functions for the syllable mnemonic encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nsm_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 64;
   localparam int DIGIT_W             = 7;
   localparam int GROUP_W             = 5;
   localparam int VOWEL_W             = 3;
   localparam int CHAR_W              = 8;
   localparam int LIMIT_W             = 4;
   localparam int DIGIT_BASE          = 100;
   localparam int DIGIT_HALF          = DIGIT_BASE / 2;
   localparam int LIMIT_MAX_ACTIVE    = 9;

   // base-100 digits needed for a width: ceil(width * log10(2) / 2)
   function automatic int digits_for_width(input int width);
      return (width * 30103 + 199999) / 200000;
   endfunction

   // d / 5 for d < 100 via reciprocal multiply
   function automatic logic [GROUP_W-1:0] digit_group(input logic [DIGIT_W-1:0] d);
      logic [14:0] prod;
      prod = 15'(d) * 15'd205;
      return prod[14:10];
   endfunction

   function automatic logic [VOWEL_W-1:0] digit_vowel(input logic [DIGIT_W-1:0] d);
      logic [GROUP_W-1:0] g;
      logic [DIGIT_W-1:0] g5;
      g  = digit_group(d);
      g5 = {g, 2'b00} + {2'b00, g};
      return VOWEL_W'(d - g5);
   endfunction

   function automatic logic [CHAR_W-1:0] cons_first(input logic [GROUP_W-1:0] g);
      logic [CHAR_W-1:0] c;
      case (g)
         5'd0:    c = "b";
         5'd1:    c = "c";
         5'd2:    c = "d";
         5'd3:    c = "f";
         5'd4:    c = "g";
         5'd5:    c = "h";
         5'd6:    c = "j";
         5'd7:    c = "k";
         5'd8:    c = "l";
         5'd9:    c = "m";
         5'd10:   c = "n";
         5'd11:   c = "p";
         5'd12:   c = "r";
         5'd13:   c = "s";
         5'd14:   c = "s";
         5'd15:   c = "t";
         5'd16:   c = "t";
         5'd17:   c = "w";
         5'd18:   c = "y";
         default: c = "z";
      endcase
      return c;
   endfunction

   // second consonant letter, zero when the group has a single letter
   function automatic logic [CHAR_W-1:0] cons_second(input logic [GROUP_W-1:0] g);
      logic [CHAR_W-1:0] c;
      case (g)
         5'd1:    c = "h";
         5'd14:   c = "h";
         5'd16:   c = "s";
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] vowel_char(input logic [VOWEL_W-1:0] v);
      logic [CHAR_W-1:0] c;
      case (v)
         3'd0:    c = "a";
         3'd1:    c = "i";
         3'd2:    c = "u";
         3'd3:    c = "e";
         default: c = "o";
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/nsm_digit_conv.sv */
// ----------------------------------------------------------------------------
// nsm_digit_conv
// Bit-serial binary to base-100 converter: one input bit per cycle, MSB
// first, each digit lane doubles itself and takes the carry of the lane below.
// ----------------------------------------------------------------------------
`default_nettype none

module nsm_digit_conv
   import nsm_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH,
   parameter int NUM_DIGITS  = digits_for_width(DEFAULT_VALUE_WIDTH)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [VALUE_WIDTH-1:0]              value,
   output logic                                     done,
   output logic [NUM_DIGITS-1:0][DIGIT_W-1:0]       digits
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0]              bits_ff, bits_in;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  digits_ff, digits_in;
   logic [CNT_W-1:0]                    cnt_ff, cnt_in;
   logic                                done_ff, done_in;
   logic [NUM_DIGITS:0]                 carry;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  step;

   always_comb begin
      carry[0] = bits_ff[VALUE_WIDTH-1];
      for (int i = 0; i < NUM_DIGITS; i++) begin
         carry[i+1] = digits_ff[i] >= DIGIT_W'(DIGIT_HALF);
         step[i]    = DIGIT_W'({digits_ff[i], 1'b0}
                         - (carry[i+1] ? 8'(DIGIT_BASE) : 8'd0))
                      + {{(DIGIT_W-1){1'b0}}, carry[i]};
      end
   end

   always_comb begin
      bits_in   = bits_ff;
      digits_in = digits_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         bits_in   = value;
         digits_in = '0;
         cnt_in    = CNT_W'(VALUE_WIDTH);
      end else if (cnt_ff != '0) begin
         bits_in   = {bits_ff[VALUE_WIDTH-2:0], 1'b0};
         digits_in = step;
         cnt_in    = cnt_ff - 1'b1;
         done_in   = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      bits_ff   <= bits_in;
      digits_ff <= digits_in;
   end

   assign done   = done_ff;
   assign digits = digits_ff;

endmodule

`default_nettype wire

/* rtl/core/number_to_syllable_mnemonic.sv */
// ----------------------------------------------------------------------------
// number_to_syllable_mnemonic
// Encodes a number as base-100 syllables, least significant digit first,
// one ASCII character per response.
// A new request is taken only in idle, re-entered once the last character
//   of a response is registered; a response has 2..30 chars, sent at one
//   character per cycle while rsp_ready allows, after the bit-serial conversion.
// Reset: synchronous; clears control state and the syllable limit to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module number_to_syllable_mnemonic
   import nsm_pkg::*;
#(
   parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [63:0]         req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [CHAR_W-1:0]        rsp_char_code,
   output logic                     rsp_is_last,
   input  wire logic                csr_wr_en,
   input  wire logic [LIMIT_W-1:0]  csr_wr_data
);

   localparam int NUM_DIGITS = digits_for_width(VALUE_WIDTH);
   localparam int IDX_W      = $clog2(NUM_DIGITS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CONV = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic [LIMIT_W-1:0]                  limit_ff, limit_in;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  dig_ff, dig_in;
   logic [IDX_W-1:0]                    left_ff, left_in;
   logic [1:0]                          pos_ff, pos_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]                   rsp_char_ff, rsp_char_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                conv_start;
   logic                                conv_done;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  conv_digits;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0]  kept;
   logic [IDX_W-1:0]                    top_idx;
   logic                                limit_on;

   logic [GROUP_W-1:0]                  grp;
   logic [CHAR_W-1:0]                   c1, c2, vc, cur_char;
   logic                                single, syl_end, out_free;

   assign req_ready  = (state_ff == S_IDLE);
   assign conv_start = req_valid && req_ready;

   nsm_digit_conv #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NUM_DIGITS  (NUM_DIGITS)
   ) u_conv (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .value  (req_value[VALUE_WIDTH-1:0]),
      .done   (conv_done),
      .digits (conv_digits)
   );

   // modulo 100^k: drop lanes at or above the limit when it is 1..9; 0 or above 9 keeps all
   always_comb begin
      limit_on = (limit_ff != '0) && (limit_ff <= LIMIT_W'(LIMIT_MAX_ACTIVE));
      top_idx  = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         kept[i] = (limit_on && (i >= int'(limit_ff))) ? '0 : conv_digits[i];
         if (kept[i] != '0) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      grp      = digit_group(dig_ff[0]);
      c1       = cons_first(grp);
      c2       = cons_second(grp);
      vc       = vowel_char(digit_vowel(dig_ff[0]));
      single   = (c2 == 8'h00);
      syl_end  = single ? (pos_ff == 2'd1) : (pos_ff == 2'd2);
      out_free = !rsp_valid_ff || rsp_ready;
      case (pos_ff)
         2'd0:    cur_char = c1;
         2'd1:    cur_char = single ? vc : c2;
         default: cur_char = vc;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      dig_in       = dig_ff;
      left_in      = left_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (conv_start) begin
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (conv_done) begin
               dig_in   = kept;
               left_in  = top_idx;
               pos_in   = 2'd0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = cur_char;
               rsp_last_in  = syl_end && (left_ff == '0);
               if (syl_end) begin
                  pos_in = 2'd0;
                  for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                     dig_in[i] = dig_ff[i+1];
                  end
                  dig_in[NUM_DIGITS-1] = '0;
                  if (left_ff == '0) begin
                     state_in = S_IDLE;
                  end else begin
                     left_in = left_ff - 1'b1;
                  end
               end else begin
                  pos_in = pos_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         limit_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= 2'd0;
         left_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff      <= dig_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;

endmodule

`default_nettype wire
